FILE: src/lcd_mode_timing_sequencer_core_defines.svh
// Assertion macros shared by the checker files.
`ifndef LCD_MODE_TIMING_SEQUENCER_CORE_DEFINES_SVH
`define LCD_MODE_TIMING_SEQUENCER_CORE_DEFINES_SVH

// Property checked while out of reset.
`define LMTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define LMTS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/lmts_pkg.sv
package lmts_pkg;

   // Field widths
   localparam int TICK_W      = 10;
   localparam int ELAPSED_W   = 8;
   localparam int COUNT_W     = 11;
   localparam int LINE_W      = 8;
   localparam int VISIBLE_W   = 8;
   localparam int BLANK_W     = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   // Register reset values
   localparam logic [TICK_W-1:0]    OAM_TICKS_RST     = 10'd80;
   localparam logic [TICK_W-1:0]    VRAM_TICKS_RST    = 10'd172;
   localparam logic [TICK_W-1:0]    HBLANK_LEN_RST    = 10'd204;
   localparam logic [TICK_W-1:0]    VBLANK_LEN_RST    = 10'd456;
   localparam logic [VISIBLE_W-1:0] VISIBLE_LINES_RST = 8'd144;
   localparam logic [BLANK_W-1:0]   BLANK_LINES_RST   = 6'd10;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OAM_TICKS     = 3'd0,
      CSR_VRAM_TICKS    = 3'd1,
      CSR_HBLANK_LEN    = 3'd2,
      CSR_VBLANK_LEN    = 3'd3,
      CSR_VISIBLE_LINES = 3'd4,
      CSR_BLANK_LINES   = 3'd5
   } csr_index_type;

   // Display modes
   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_VRAM   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [TICK_W-1:0]    oam_ticks;
      logic [TICK_W-1:0]    vram_ticks;
      logic [TICK_W-1:0]    hblank_len;
      logic [TICK_W-1:0]    vblank_len;
      logic [VISIBLE_W-1:0] visible_lines;
      logic [BLANK_W-1:0]   blank_lines;
   } cfg_type;

   typedef struct packed {
      mode_type          mode;
      logic [LINE_W-1:0] line;
      logic              render;
      logic              frame;
   } result_type;

endpackage

FILE: src/lmts_csr.sv
module lmts_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [lmts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lmts_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output lmts_pkg::cfg_type                 cfg
);
   import lmts_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write; unknown indexes leave everything alone
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OAM_TICKS:     cfg_in.oam_ticks     = csr_wdata[TICK_W-1:0];
            CSR_VRAM_TICKS:    cfg_in.vram_ticks    = csr_wdata[TICK_W-1:0];
            CSR_HBLANK_LEN:    cfg_in.hblank_len    = csr_wdata[TICK_W-1:0];
            CSR_VBLANK_LEN:    cfg_in.vblank_len    = csr_wdata[TICK_W-1:0];
            CSR_VISIBLE_LINES: cfg_in.visible_lines = csr_wdata[VISIBLE_W-1:0];
            CSR_BLANK_LINES:   cfg_in.blank_lines   = csr_wdata[BLANK_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.oam_ticks     <= OAM_TICKS_RST;
         cfg_ff.vram_ticks    <= VRAM_TICKS_RST;
         cfg_ff.hblank_len    <= HBLANK_LEN_RST;
         cfg_ff.vblank_len    <= VBLANK_LEN_RST;
         cfg_ff.visible_lines <= VISIBLE_LINES_RST;
         cfg_ff.blank_lines   <= BLANK_LINES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/lmts_step.sv
module lmts_step (
   input  logic                            clock,
   input  logic                            reset,
   input  lmts_pkg::cfg_type               cfg,
   input  logic                            fire,
   input  logic [lmts_pkg::ELAPSED_W-1:0]  elapsed_ticks,
   output lmts_pkg::result_type            result
);
   import lmts_pkg::*;

   mode_type             mode_ff;
   mode_type             mode_in;
   logic [COUNT_W-1:0]   tick_ff;
   logic [COUNT_W-1:0]   tick_in;
   logic [LINE_W-1:0]    line_ff;
   logic [LINE_W-1:0]    line_in;

   logic [COUNT_W:0]     tick_sum;
   logic [COUNT_W-1:0]   tick_sat;
   logic [TICK_W-1:0]    threshold;
   logic                 reached;
   logic [LINE_W-1:0]    last_line;
   logic [LINE_W-1:0]    line_inc;
   logic [LINE_W:0]      frame_lines;
   logic                 last_visible;
   logic                 vblank_wrap;
   logic                 render;
   logic                 frame;

   // Accumulate with saturation at the counter's top value
   assign tick_sum = {1'b0, tick_ff} + (COUNT_W+1)'(elapsed_ticks);
   assign tick_sat = tick_sum[COUNT_W] ? {COUNT_W{1'b1}} : tick_sum[COUNT_W-1:0];

   // Threshold of the mode in force
   always_comb begin
      case (mode_ff)
         MODE_OAM:    threshold = cfg.oam_ticks;
         MODE_VRAM:   threshold = cfg.vram_ticks;
         MODE_HBLANK: threshold = cfg.hblank_len;
         default:     threshold = cfg.vblank_len;
      endcase
   end

   assign reached      = tick_sat >= COUNT_W'(threshold);
   assign last_line    = cfg.visible_lines - LINE_W'(1);
   assign line_inc     = line_ff + LINE_W'(1);
   assign frame_lines  = (LINE_W+1)'(cfg.visible_lines) + (LINE_W+1)'(cfg.blank_lines);
   assign last_visible = line_ff == last_line;
   assign vblank_wrap  = (LINE_W+1)'(line_inc) >= frame_lines;

   // Next mode
   always_comb begin
      mode_in = mode_ff;
      if (reached) begin
         case (mode_ff)
            MODE_OAM:    mode_in = MODE_VRAM;
            MODE_VRAM:   mode_in = MODE_HBLANK;
            MODE_HBLANK: mode_in = last_visible ? MODE_VBLANK : MODE_OAM;
            MODE_VBLANK: mode_in = vblank_wrap ? MODE_OAM : MODE_VBLANK;
            default:     mode_in = mode_ff;
         endcase
      end
   end

   // Counter, line and event pulses
   always_comb begin
      tick_in = reached ? '0 : tick_sat;
      line_in = line_ff;
      render  = 1'b0;
      frame   = 1'b0;
      if (reached) begin
         case (mode_ff)
            MODE_VRAM: render = 1'b1;
            MODE_HBLANK: begin
               line_in = line_inc;
               frame   = last_visible;
            end
            MODE_VBLANK: line_in = vblank_wrap ? '0 : line_inc;
            default:     line_in = line_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HBLANK;
         tick_ff <= '0;
         line_ff <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         tick_ff <= tick_in;
         line_ff <= line_in;
      end
   end

   assign result.mode   = mode_in;
   assign result.line   = line_in;
   assign result.render = render;
   assign result.frame  = frame;

endmodule

FILE: src/lcd_mode_timing_sequencer_core.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_elapsed_ticks[7:0]
// rsp_      out        rsp_valid/rsp_stall  rsp_display_mode, rsp_current_line,
//                                           rsp_line_render, rsp_frame_done
// csr_      in         csr_we               csr_index[2:0], csr_wdata[9:0]
//
// A request passes through the input register and the result register to the response;
// one transaction per cycle is sustained while the response is not stalled, set by the
// combinational add, compare and mode update on the sequencer state.
// Reset is synchronous and active high; valid flags, configuration and sequencer state return to defaults.
// A stalled response holds the output register; the input register keeps
// taking a transaction while the output register is empty or being drained.
module lcd_mode_timing_sequencer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lmts_pkg::ELAPSED_W-1:0]    req_elapsed_ticks,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_display_mode,
   output logic [lmts_pkg::LINE_W-1:0]       rsp_current_line,
   output logic                              rsp_line_render,
   output logic                              rsp_frame_done,
   input  logic                              csr_we,
   input  logic [lmts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lmts_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lmts_pkg::*;

   cfg_type                cfg;
   result_type             result;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [ELAPSED_W-1:0]   in_ticks_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   result_type             out_ff;
   logic                   advance;
   logic                   fire;
   logic                   req_take;

   lmts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lmts_step u_step (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .fire          (fire),
      .elapsed_ticks (in_ticks_ff),
      .result        (result)
   );

   // Pipeline control
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ticks_ff <= req_elapsed_ticks;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_display_mode = out_ff.mode;
   assign rsp_current_line = out_ff.line;
   assign rsp_line_render  = out_ff.render;
   assign rsp_frame_done   = out_ff.frame;

endmodule

FILE: src/lmts_checker.sv
`include "lcd_mode_timing_sequencer_core_defines.svh"

module lmts_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [1:0]                        rsp_display_mode,
   input  logic [lmts_pkg::LINE_W-1:0]       rsp_current_line,
   input  logic                              rsp_line_render,
   input  logic                              rsp_frame_done
);
   import lmts_pkg::*;

   logic [LINE_W+3:0] rsp_payload;

   // Response fields as one word
   assign rsp_payload = {rsp_display_mode, rsp_current_line, rsp_line_render, rsp_frame_done};

   // A stalled response stays put
   `LMTS_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload),
      "response changed while stalled")

   // Render pulse only on the VRAM to HBLANK transition
   `LMTS_ASSERT(a_render_mode, clock, reset,
      rsp_valid && rsp_line_render |-> rsp_display_mode == MODE_HBLANK,
      "line render outside HBLANK")

   // Frame pulse only on entry to VBLANK
   `LMTS_ASSERT(a_frame_mode, clock, reset,
      rsp_valid && rsp_frame_done |-> rsp_display_mode == MODE_VBLANK && !rsp_line_render,
      "frame done outside VBLANK entry")

   // Nothing pending right after reset
   `LMTS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind lcd_mode_timing_sequencer_core lmts_checker u_lmts_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_display_mode (rsp_display_mode),
   .rsp_current_line (rsp_current_line),
   .rsp_line_render  (rsp_line_render),
   .rsp_frame_done   (rsp_frame_done)
);

FILE: dv/lcd_mode_timing_sequencer_core_test.sv
module lcd_mode_timing_sequencer_core_test;
   import lmts_pkg::*;

   // Index codes the block has no register for; writes to them are dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SPARE_HI = 3'd7;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 30;
   localparam int HOLD_CYCLES = 300;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ELAPSED_W-1:0]   req_elapsed_ticks = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_display_mode;
   logic [LINE_W-1:0]      rsp_current_line;
   logic                   rsp_line_render;
   logic                   rsp_frame_done;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_OAM_TICKS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   lcd_mode_timing_sequencer_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_elapsed_ticks (req_elapsed_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_display_mode  (rsp_display_mode),
      .rsp_current_line  (rsp_current_line),
      .rsp_line_render   (rsp_line_render),
      .rsp_frame_done    (rsp_frame_done),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Sequencer mirror: registers and state
   cfg_type           seq_cfg;
   mode_type          seq_mode;
   logic [COUNT_W-1:0] seq_ticks;
   logic [LINE_W-1:0] seq_line;

   result_type pending_timing[$];
   int         mismatch_count = 0;
   int         cycle_count = 0;
   bit         send_idle_on = 1'b1;
   bit         recv_idle_on = 1'b1;
   bit         hold_request = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Cycle counter; a hung handshake ends the run here
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   function automatic void reset_sequencer();
      seq_cfg.oam_ticks     = OAM_TICKS_RST;
      seq_cfg.vram_ticks    = VRAM_TICKS_RST;
      seq_cfg.hblank_len    = HBLANK_LEN_RST;
      seq_cfg.vblank_len    = VBLANK_LEN_RST;
      seq_cfg.visible_lines = VISIBLE_LINES_RST;
      seq_cfg.blank_lines   = BLANK_LINES_RST;
      seq_mode  = MODE_HBLANK;
      seq_ticks = '0;
      seq_line  = '0;
   endfunction

   // Registers keep only their own width; unknown indexes are ignored
   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_OAM_TICKS:     seq_cfg.oam_ticks     = data[TICK_W-1:0];
         CSR_VRAM_TICKS:    seq_cfg.vram_ticks    = data[TICK_W-1:0];
         CSR_HBLANK_LEN:    seq_cfg.hblank_len    = data[TICK_W-1:0];
         CSR_VBLANK_LEN:    seq_cfg.vblank_len    = data[TICK_W-1:0];
         CSR_VISIBLE_LINES: seq_cfg.visible_lines = data[VISIBLE_W-1:0];
         CSR_BLANK_LINES:   seq_cfg.blank_lines   = data[BLANK_W-1:0];
         default: ;
      endcase
   endfunction

   // One instruction's ticks: accumulate, compare, step the mode machine
   function automatic result_type advance_sequencer(input logic [ELAPSED_W-1:0] ticks);
      result_type        r;
      logic [11:0]       sum;
      logic [LINE_W-1:0] next_line;
      sum = {1'b0, seq_ticks} + {4'b0, ticks};
      if (sum > 12'd2047) sum = 12'd2047;
      seq_ticks = sum[COUNT_W-1:0];
      r.render = 1'b0;
      r.frame  = 1'b0;
      case (seq_mode)
         MODE_OAM: begin
            if (seq_ticks >= {1'b0, seq_cfg.oam_ticks}) begin
               seq_ticks = '0;
               seq_mode  = MODE_VRAM;
            end
         end
         MODE_VRAM: begin
            if (seq_ticks >= {1'b0, seq_cfg.vram_ticks}) begin
               seq_ticks = '0;
               seq_mode  = MODE_HBLANK;
               r.render  = 1'b1;
            end
         end
         MODE_HBLANK: begin
            if (seq_ticks >= {1'b0, seq_cfg.hblank_len}) begin
               seq_ticks = '0;
               // last visible line wraps: zero visible lines means line 255
               if (seq_line == seq_cfg.visible_lines - 8'd1) begin
                  seq_mode = MODE_VBLANK;
                  r.frame  = 1'b1;
               end else begin
                  seq_mode = MODE_OAM;
               end
               seq_line = seq_line + 8'd1;
            end
         end
         default: begin
            if (seq_ticks >= {1'b0, seq_cfg.vblank_len}) begin
               next_line = seq_line + 8'd1;
               seq_ticks = '0;
               // a sum past 255 is never reached, so vblank runs on
               if (int'(next_line) >=
                   int'(seq_cfg.visible_lines) + int'(seq_cfg.blank_lines)) begin
                  seq_mode  = MODE_OAM;
                  next_line = '0;
               end
               seq_line = next_line;
            end
         end
      endcase
      r.mode = seq_mode;
      r.line = seq_line;
      return r;
   endfunction

   function automatic logic [ELAPSED_W-1:0] random_ticks();
      if ($urandom_range(99) < 25) return ELAPSED_W'($urandom_range(3, 0));
      return ELAPSED_W'($urandom_range(255, 0));
   endfunction

   // Offer one transaction, with random gaps ahead of it
   task automatic send_instruction_ticks(input logic [ELAPSED_W-1:0] ticks);
      while (send_idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_elapsed_ticks <= ticks;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_timing.push_back(advance_sequencer(ticks));
   endtask

   task automatic send_random_ticks(input int count);
      repeat (count) send_instruction_ticks(random_ticks());
   endtask

   // Stop offering and wait until every result is back
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_timing.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_register(idx, data);
      @(posedge clock);
   endtask

   task automatic write_timing(input logic [CSR_DATA_W-1:0] oam,
                               input logic [CSR_DATA_W-1:0] vram,
                               input logic [CSR_DATA_W-1:0] hblank,
                               input logic [CSR_DATA_W-1:0] vblank,
                               input logic [CSR_DATA_W-1:0] visible,
                               input logic [CSR_DATA_W-1:0] blank);
      write_register(CSR_OAM_TICKS, oam);
      write_register(CSR_VRAM_TICKS, vram);
      write_register(CSR_HBLANK_LEN, hblank);
      write_register(CSR_VBLANK_LEN, vblank);
      write_register(CSR_VISIBLE_LINES, visible);
      write_register(CSR_BLANK_LINES, blank);
   endtask

   // Reset defaults, idle tick counts and the largest ones
   task automatic test_tick_extremes();
      send_instruction_ticks(8'd0);
      send_instruction_ticks(8'd255);
      send_instruction_ticks(8'd79);
      send_instruction_ticks(8'd1);
      send_instruction_ticks(8'd255);
      send_instruction_ticks(8'd128);
      wait_until_idle();
   endtask

   // Zero thresholds advance every transaction: render, frame, vblank wrap
   task automatic test_zero_thresholds();
      write_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd3, 10'd1);
      repeat (9) send_instruction_ticks(8'd0);
      wait_until_idle();
   endtask

   // Upper bits dropped, spare indexes ignored, zero visible lines
   task automatic test_register_masking();
      write_timing(10'd1, 10'd1, 10'd1, 10'd1, 10'h300, 10'h3C1);
      write_register(CSR_INDEX_SPARE_LO, 10'h3FF);
      write_register(CSR_INDEX_SPARE_HI, 10'h000);
      send_instruction_ticks(8'd1);
      send_instruction_ticks(8'd0);
      send_instruction_ticks(8'd2);
      send_instruction_ticks(8'd255);
      send_instruction_ticks(8'd1);
      send_instruction_ticks(8'd0);
      wait_until_idle();
   endtask

   // Long receiver hold-off fills the block; then a pause until drained
   task automatic test_backpressure();
      write_timing(10'd40, 10'd60, 10'd50, 10'd100, 10'd4, 10'd2);
      send_idle_on = 1'b0;
      hold_request = 1'b1;
      send_random_ticks(40);
      send_idle_on = 1'b1;
      wait_until_idle();
      send_random_ticks(10);
      wait_until_idle();
   endtask

   task automatic test_random_settings();
      write_timing(OAM_TICKS_RST, VRAM_TICKS_RST, HBLANK_LEN_RST,
                   VBLANK_LEN_RST, 10'(VISIBLE_LINES_RST), 10'(BLANK_LINES_RST));
      send_random_ticks(20);
      wait_until_idle();
      write_timing(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1, 10'd1);
      send_random_ticks(20);
      wait_until_idle();
      write_timing(10'd1, 10'd1, 10'd1, 10'd1, 10'd200, 10'd55);
      send_random_ticks(20);
      wait_until_idle();
      repeat (3) begin
         write_timing(10'($urandom_range(200, 0)), 10'($urandom_range(200, 0)),
                      10'($urandom_range(200, 0)), 10'($urandom_range(200, 0)),
                      10'($urandom_range(3, 1)), 10'($urandom_range(3, 1)));
         send_random_ticks(10);
         wait_until_idle();
      end
   endtask

   // Zero visible lines: run until line 255 ends and vblank starts, then
   // widen the frame past 256 lines so vblank wraps the line and never ends
   task automatic test_line_wrap();
      int n;
      write_timing(10'($urandom_range(2, 0)), 10'($urandom_range(2, 0)),
                   10'($urandom_range(2, 0)), 10'($urandom_range(2, 0)),
                   10'd0, 10'd1);
      n = 0;
      while (n < 1200 && !(n > 300 && seq_mode == MODE_VBLANK)) begin
         send_instruction_ticks(random_ticks());
         n++;
      end
      wait_until_idle();
      write_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'h3FF, 10'h3FF);
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      send_random_ticks(270);
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      wait_until_idle();
   endtask

   initial begin
      reset_sequencer();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tick_extremes();
      test_zero_thresholds();
      test_register_masking();
      test_backpressure();
      test_random_settings();
      test_line_wrap();
      wait_until_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Receiver pacing: random stalls, or a long hold when requested
   initial begin : response_pacing
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_idle_on) begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted result transaction with the oldest prediction
   always @(posedge clock) begin : check_timing
      result_type got;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.mode   = mode_type'(rsp_display_mode);
         got.line   = rsp_current_line;
         got.render = rsp_line_render;
         got.frame  = rsp_frame_done;
         if (pending_timing.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result mode %0d line %0d render %0b frame %0b",
                     $time, got.mode, got.line, got.render, got.frame);
         end else begin
            want = pending_timing.pop_front();
            if (got.mode !== want.mode || got.line !== want.line ||
                got.render !== want.render || got.frame !== want.frame) begin
               mismatch_count++;
               $display("%0t: mismatch expected mode %0d line %0d render %0b frame %0b",
                        $time, want.mode, want.line, want.render, want.frame);
               $display("%0t:          actual   mode %0d line %0d render %0b frame %0b",
                        $time, got.mode, got.line, got.render, got.frame);
            end
         end
      end
   end

endmodule

FILE: filelist.f
+incdir+src
src/lmts_pkg.sv
src/lmts_csr.sv
src/lmts_step.sv
src/lcd_mode_timing_sequencer_core.sv
src/lmts_checker.sv
dv/lcd_mode_timing_sequencer_core_test.sv
